// ===== rtl/fbr_pkg.sv =====
// Shared types, constants and helpers for the fabric bandwidth reservation unit.
package fbr_pkg;

	localparam int PORTS      = 16;              // power of two, at least 2
	localparam int PORT_W     = $clog2(PORTS);
	localparam int TIME_W     = 48;
	localparam int BYTES_W    = 32;
	localparam int RATE_W     = 16;
	localparam int LAT_W      = 20;
	localparam int FRAC_W     = 8;               // Q8.8 rate: dividend is bytes << 8
	localparam int DIV_W      = BYTES_W + FRAC_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = LAT_W;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(256);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_AGG_RATE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_PORT_RATE = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_LAT = CFG_IDX_W'(2);

	typedef struct packed {
		logic [TIME_W-1:0]  request_time;
		logic [BYTES_W-1:0] byte_count;
		logic [15:0]        port_number;
	} req_t;

	typedef struct packed {
		logic [TIME_W-1:0] issued_time;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] end_time;
		logic [TIME_W-1:0] delivered_time;
	} rsp_t;

	// classified request handed from front to back
	typedef struct packed {
		logic [TIME_W-1:0] request_time;
		logic [DIV_W-1:0]  dividend;
		logic [PORT_W-1:0] port;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_UPDATE,
		ST_END,
		ST_DELIVER
	} fbr_state_t;

	// saturating time add
	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] max_time(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ===== rtl/fbr_front.sv =====
// Front end: classifies request beats and holds them in a two-entry queue.
module fbr_front import fbr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_t req,
	output logic job_valid,
	input  logic job_ready,
	output job_t job
);

	job_t        mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        do_push;
	logic        do_pop;
	job_t        job_in;

	assign full      = (count_q == 2'd2);
	assign job_valid = (count_q != 2'd0);
	assign job       = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = job_valid && job_ready;

	// port taken modulo PORTS, bytes scaled for the Q8.8 rate
	always_comb begin
		job_in.request_time = req.request_time;
		job_in.dividend     = {req.byte_count, FRAC_W'(0)};
		job_in.port         = req.port_number[PORT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= job_in;
	end

endmodule

// ===== rtl/fbr_divider.sv =====
// Restoring divider, one quotient bit per cycle, result rounded up.
module fbr_divider import fbr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [RATE_W-1:0] divisor,
	output logic              done,
	output logic [DIV_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	logic [DIV_W-1:0]  acc_q;
	logic [RATE_W-1:0] rem_q;
	logic [RATE_W-1:0] den_q;
	logic [RATE_W:0]   trial;
	logic [RATE_W:0]   diff;
	logic              qbit;
	logic [RATE_W-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, acc_q[DIV_W-1]};
		diff    = trial - {1'b0, den_q};
		qbit    = (trial >= {1'b0, den_q});
		rem_nxt = qbit ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
	end

	// ceiling: bump when a remainder is left
	assign quotient = acc_q + DIV_W'(rem_q != '0);
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (count_q == CNT_W'(1));
			if (start)
				count_q <= CNT_W'(DIV_W);
			else if (count_q != '0)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (count_q != '0) begin
			acc_q <= {acc_q[DIV_W-2:0], qbit};
			rem_q <= rem_nxt;
		end
	end

endmodule

// ===== rtl/fbr_back.sv =====
// Back end: booking sequencer, free-time state and the result register.
module fbr_back import fbr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  job_t              job,
	input  logic [RATE_W-1:0] agg_rate,
	input  logic [RATE_W-1:0] port_rate,
	input  logic [LAT_W-1:0]  fixed_lat,
	output logic              empty,
	input  logic              pop,
	output rsp_t              rsp
);

	fbr_state_t        state_q, state_d;
	logic              div_start;
	logic              rsp_load;
	logic              agg_done, port_done;
	logic [DIV_W-1:0]  agg_quot, port_quot;
	logic [RATE_W-1:0] agg_den, port_den;
	logic [TIME_W-1:0] start_now;

	logic [TIME_W-1:0] agg_busy_q;
	logic [TIME_W-1:0] port_busy_q [PORTS];
	logic              rsp_valid_q;

	job_t              job_q;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] port_new_q;
	logic [TIME_W-1:0] end_q;
	rsp_t              rsp_q;

	// a zero rate counts as the smallest rate
	assign agg_den  = (agg_rate  == '0) ? RATE_W'(1) : agg_rate;
	assign port_den = (port_rate == '0) ? RATE_W'(1) : port_rate;

	assign start_now = max_time(job.request_time,
		max_time(agg_busy_q, port_busy_q[job.port]));

	fbr_divider u_agg_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (job.dividend),
		.divisor  (agg_den),
		.done     (agg_done),
		.quotient (agg_quot)
	);

	fbr_divider u_port_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (job.dividend),
		.divisor  (port_den),
		.done     (port_done),
		.quotient (port_quot)
	);

	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		div_start = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					job_ready = 1'b1;
					div_start = 1'b1;
					state_d   = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (agg_done && port_done) state_d = ST_UPDATE;
			end
			ST_UPDATE: state_d = ST_END;
			ST_END:    state_d = ST_DELIVER;
			ST_DELIVER: begin
				if (!rsp_valid_q || pop) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			agg_busy_q  <= '0;
			for (int i = 0; i < PORTS; i++) port_busy_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (pop)
				rsp_valid_q <= 1'b0;
			if (state_q == ST_UPDATE) begin
				agg_busy_q              <= sat_add(start_q, TIME_W'(agg_quot));
				port_busy_q[job_q.port] <= sat_add(start_q, TIME_W'(port_quot));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			job_q   <= job;
			start_q <= start_now;
		end
		if (state_q == ST_UPDATE) port_new_q <= sat_add(start_q, TIME_W'(port_quot));
		if (state_q == ST_END)    end_q      <= max_time(agg_busy_q, port_new_q);
		if (rsp_load) begin
			rsp_q.issued_time    <= job_q.request_time;
			rsp_q.start_time     <= start_q;
			rsp_q.end_time       <= end_q;
			rsp_q.delivered_time <= sat_add(end_q, TIME_W'(fixed_lat));
		end
	end

	assign empty = !rsp_valid_q;
	assign rsp   = rsp_q;

endmodule

// ===== rtl/fabric_bandwidth_reservation_unit.sv =====
// Top level of the fabric bandwidth reservation unit.
//
// Books transfer windows on a fabric with one aggregate and sixteen per-port
// bandwidth limits. Request beats enter on push/full with the req struct;
// a beat is taken on a rising edge with push high and full low. Results leave
// on empty/pop: the oldest result sits on rsp while empty is low and is taken
// on an edge with pop high.
// Configuration: cfg_we writes cfg_wdata into register cfg_idx (0 aggregate
// rate, 1 port rate, 2 fixed latency), truncated to the register width; index
// 3 is ignored. Write only while the unit is idle.
// The front end queues up to two classified requests. The back end runs two
// 40-step bit-serial dividers in parallel (one per rate), so each request
// occupies the back end while it is taken, divided, flagged done and then
// passed through update, end and deliver; the back end takes no new request
// until the previous one has been delivered to the output register.
// A pending result waits in an output register; while it is not popped the
// back end holds its next finished result, and the front queue fills and then
// raises full.
// Reset clears both queues and all free times; rates return to 1.0 byte/ns
// and the fixed latency to zero.
module fabric_bandwidth_reservation_unit import fbr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  req_t                  req,
	output logic                  empty,
	input  logic                  pop,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic              job_valid;
	logic              job_ready;
	job_t              job;
	logic [RATE_W-1:0] agg_rate_q;
	logic [RATE_W-1:0] port_rate_q;
	logic [LAT_W-1:0]  fixed_lat_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agg_rate_q  <= RATE_RESET;
			port_rate_q <= RATE_RESET;
			fixed_lat_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_AGG_RATE:  agg_rate_q  <= cfg_wdata[RATE_W-1:0];
				CFG_PORT_RATE: port_rate_q <= cfg_wdata[RATE_W-1:0];
				CFG_FIXED_LAT: fixed_lat_q <= cfg_wdata[LAT_W-1:0];
				default: ;
			endcase
		end
	end

	fbr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	fbr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.agg_rate  (agg_rate_q),
		.port_rate (port_rate_q),
		.fixed_lat (fixed_lat_q),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp)
	);

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the fabric bandwidth reservation unit.
module tb_top;
	import fbr_pkg::*;

	// index past the last register: the unit must drop writes to it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);
	localparam logic [LAT_W-1:0]     LAT_MAX    = '1;
	localparam logic [RATE_W-1:0]    RATE_MAX   = '1;

	// no beat on either side for this long means the unit is stuck;
	// longest legal quiet stretch is the receiver hold-off plus one job
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_OFF    = 600;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	req_t                  req;
	logic                  empty;
	logic                  pop;
	rsp_t                  rsp;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	fabric_bandwidth_reservation_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// 12-unit period, starts low so the first rising edge is at 6
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ---------------------------------------------------------------
	// Booking model: our own copy of the registers and free times
	// ---------------------------------------------------------------
	logic [RATE_W-1:0] agg_rate_m;
	logic [RATE_W-1:0] port_rate_m;
	logic [LAT_W-1:0]  latency_m;
	logic [TIME_W-1:0] agg_free_m;
	logic [TIME_W-1:0] port_free_m [PORTS];

	// windows booked but not yet seen on the result side, oldest first
	rsp_t pending_windows[$];
	rsp_t oldest_window;

	int mismatches   = 0;
	int items_sent   = 0;
	int windows_seen = 0;
	int reg_writes   = 0;

	// traffic shaping, read by the sender task and the receiver process
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_cycles    = 0;
	int stall_count;

	// time sum clamped to the 48-bit ceiling
	function automatic logic [TIME_W-1:0] clamp_sum(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		longint unsigned total;
		total = longint'(a) + longint'(b);
		if (total > longint'(TIME_MAX))
			return TIME_MAX;
		return total[TIME_W-1:0];
	endfunction

	// ceil((bytes << 8) / rate); a zero rate counts as the slowest rate
	function automatic logic [TIME_W-1:0] transfer_ns(input logic [BYTES_W-1:0] bytes,
			input logic [RATE_W-1:0] rate);
		longint unsigned divisor;
		longint unsigned dividend;
		divisor  = (rate == '0) ? 64'd1 : longint'(rate);
		dividend = longint'(bytes) << FRAC_W;
		return TIME_W'((dividend + divisor - 1) / divisor);
	endfunction

	// books one window and moves both free times forward
	function automatic rsp_t book_window(input req_t r);
		rsp_t              w;
		int                p;
		logic [TIME_W-1:0] begin_at;
		logic [TIME_W-1:0] done_at;
		p = int'(r.port_number % PORTS);
		begin_at = r.request_time;
		if (agg_free_m > begin_at)
			begin_at = agg_free_m;
		if (port_free_m[p] > begin_at)
			begin_at = port_free_m[p];
		agg_free_m     = clamp_sum(begin_at, transfer_ns(r.byte_count, agg_rate_m));
		port_free_m[p] = clamp_sum(begin_at, transfer_ns(r.byte_count, port_rate_m));
		done_at = (agg_free_m > port_free_m[p]) ? agg_free_m : port_free_m[p];
		w.issued_time    = r.request_time;
		w.start_time     = begin_at;
		w.end_time       = done_at;
		w.delivered_time = clamp_sum(done_at, TIME_W'(latency_m));
		return w;
	endfunction

	// ---------------------------------------------------------------
	// Shared drivers
	// ---------------------------------------------------------------

	// Enter and leave at a falling edge. push is left high so that
	// back-to-back beats never see it drop; idle gaps lower it.
	task automatic send_item(input req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		req  = r;
		do
			@(posedge clk);
		while (full);
		pending_windows.insert(pending_windows.size(), book_window(r));
		items_sent++;
		@(negedge clk);
	endtask

	// one register write; cfg_we stays high until the caller ends the burst
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_idx   = idx;
		cfg_wdata = data;
		@(posedge clk);
		case (idx)
			CFG_AGG_RATE:  agg_rate_m  = data[RATE_W-1:0];
			CFG_PORT_RATE: port_rate_m = data[RATE_W-1:0];
			CFG_FIXED_LAT: latency_m   = data[LAT_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [CFG_DATA_W-1:0] agg,
			input logic [CFG_DATA_W-1:0] prt, input logic [CFG_DATA_W-1:0] lat);
		write_reg(CFG_AGG_RATE, agg);
		write_reg(CFG_PORT_RATE, prt);
		write_reg(CFG_FIXED_LAT, lat);
		cfg_we = 1'b0;
	endtask

	// stop offering and wait for every booked window to come back;
	// every request yields a result, so an empty queue means idle
	task automatic wait_idle();
		push = 1'b0;
		while (pending_windows.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic req_t make_req(input logic [TIME_W-1:0] t,
			input logic [BYTES_W-1:0] n, input logic [15:0] port);
		req_t r;
		r.request_time = t;
		r.byte_count   = n;
		r.port_number  = port;
		return r;
	endfunction

	// Random request. Times mostly land near a current free time so that
	// the aggregate and port limits fight over the start; a rare full-width
	// time exercises the upper bits without running the clock into the ceiling.
	function automatic req_t random_request();
		req_t           r;
		longint         t;
		longint         base;
		int             pick;
		pick = $urandom_range(99);
		r.port_number = 16'($urandom);
		if (pick < 45)
			base = longint'(agg_free_m);
		else if (pick < 85)
			base = longint'(port_free_m[int'(r.port_number % PORTS)]);
		else if (pick < 98)
			base = 0;
		else
			base = longint'({16'($urandom), 32'($urandom)});
		t = base + longint'($urandom_range(4000)) - 2000;
		if (t < 0)
			t = 0;
		if (t > longint'(TIME_MAX))
			t = longint'(TIME_MAX);
		r.request_time = t[TIME_W-1:0];
		case ($urandom_range(19))
			0:       r.byte_count = '0;
			1:       r.byte_count = '1;
			2, 3:    r.byte_count = $urandom;
			4, 5, 6,
			7, 8:    r.byte_count = $urandom_range(255);
			default: r.byte_count = $urandom_range(8192);
		endcase
		return r;
	endfunction

	// rate picks lean on the extremes; zero is out of range but legal to write
	function automatic logic [RATE_W-1:0] random_rate();
		case ($urandom_range(9))
			0:       return RATE_W'(1);
			1:       return RATE_MAX;
			2:       return '0;
			3:       return RATE_W'(256);
			default: return RATE_W'($urandom);
		endcase
	endfunction

	function automatic logic [LAT_W-1:0] random_latency();
		case ($urandom_range(3))
			0:       return '0;
			1:       return LAT_MAX;
			default: return LAT_W'($urandom);
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// reset rates (1.0 byte/ns, no latency): zero bytes, port aliasing,
	// requests behind a busy link, a full 32-bit byte count
	task automatic test_reset_defaults();
		send_item(make_req(48'd0, 32'd0, 16'h0000));
		send_item(make_req(48'd100, 32'd1, 16'hFFFF));
		send_item(make_req(48'd100, 32'd64, 16'h0010));
		send_item(make_req(48'd50, 32'd4096, 16'h8000));
		send_item(make_req(48'd0, 32'd300, 16'h000F));
		send_item(make_req(48'd1_000_000, 32'hFFFF_FFFF, 16'h0003));
		wait_idle();
	endtask

	// register extremes; junk above the rate width must be dropped,
	// a write to the unused index must change nothing, zero rates act as one
	task automatic test_register_extremes();
		write_reg(CFG_AGG_RATE, 20'hF0001);
		write_reg(CFG_PORT_RATE, 20'h5FFFF);
		write_reg(CFG_FIXED_LAT, LAT_MAX);
		write_reg(CFG_UNUSED, 20'hA5A5A);
		cfg_we = 1'b0;
		send_item(make_req(48'd0, 32'd1, 16'h0001));
		send_item(make_req(48'd0, 32'd255, 16'h0002));
		send_item(make_req(48'd20_000_000_000, 32'd256, 16'h0001));
		send_item(make_req(48'd0, 32'h0001_0000, 16'h0011));
		wait_idle();
		set_regs(20'hA0000, 20'h30000, '0);
		send_item(make_req(48'd0, 32'd3, 16'h0004));
		send_item(make_req(48'd0, 32'd1000, 16'h0024));
		send_item(make_req(48'h0000_FFFF_FFFF, 32'd1, 16'h0005));
		wait_idle();
		set_regs(20'd256, 20'd256, 20'd1234);
		send_item(make_req(48'd0, 32'd512, 16'h0006));
		send_item(make_req(48'd0, 32'd512, 16'h0007));
		wait_idle();
	endtask

	// receiver holds off long enough for the unit to fill and raise full
	// while the sender keeps offering beats
	task automatic test_long_hold_off();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = HOLD_OFF;
		repeat (16) send_item(random_request());
		wait_idle();
	endtask

	// sender stops until the unit has handed back every window, then resumes
	task automatic test_sender_pause();
		send_idle_pct  = 45;
		recv_stall_pct = 45;
		repeat (10) send_item(random_request());
		wait_idle();
		repeat (10) send_item(random_request());
		wait_idle();
	endtask

	// four traffic mixes, each under two fresh register settings
	task automatic test_random_traffic();
		int idle_mix[4]  = '{0, 45, 0, 36};
		int stall_mix[4] = '{0, 0, 45, 36};
		for (int ph = 0; ph < 4; ph++) begin
			for (int k = 0; k < 2; k++) begin
				wait_idle();
				set_regs({4'($urandom), random_rate()}, {4'($urandom), random_rate()},
						random_latency());
				if ($urandom_range(1)) begin
					write_reg(CFG_UNUSED, 20'($urandom));
					cfg_we = 1'b0;
				end
				send_idle_pct  = idle_mix[ph];
				recv_stall_pct = stall_mix[ph];
				repeat (140) send_item(random_request());
			end
		end
		wait_idle();
	endtask

	// Last on purpose: free times only grow and reset is not repeated,
	// so once they hit the ceiling every later window is pinned there.
	task automatic test_time_ceiling();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_regs(20'd1, 20'd1, LAT_MAX);
		send_item(make_req(TIME_MAX - 48'd1000, 32'hFFFF_FFFF, 16'h0005));
		send_item(make_req(TIME_MAX, 32'd7, 16'hFFFF));
		send_item(make_req(48'd0, 32'd1, 16'h0002));
		wait_idle();
		set_regs(CFG_DATA_W'(RATE_MAX), CFG_DATA_W'(RATE_MAX), '0);
		send_item(make_req(TIME_MAX - 48'd10, 32'h0000_0100, 16'h0009));
		wait_idle();
	endtask

	// ---------------------------------------------------------------
	// Result side
	// ---------------------------------------------------------------

	// pop changes at the falling edge; a hold-off request wins over random stalls
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				pop = 1'b0;
				hold_cycles--;
			end else begin
				pop = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic check_field(input string what, input logic [TIME_W-1:0] want_v,
			input logic [TIME_W-1:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want_v,
					got_v);
			mismatches++;
		end
	endtask

	// every popped beat is matched against the oldest booked window
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			windows_seen++;
			if (pending_windows.size() == 0) begin
				$display("%0t: result beat with nothing booked: expected none, actual %h",
						$time, rsp);
				mismatches++;
			end else begin
				oldest_window = pending_windows.pop_front();
				check_field("issued_time", oldest_window.issued_time, rsp.issued_time);
				check_field("start_time", oldest_window.start_time, rsp.start_time);
				check_field("end_time", oldest_window.end_time, rsp.end_time);
				check_field("delivered_time", oldest_window.delivered_time,
						rsp.delivered_time);
			end
		end
	end

	// watchdog: ends the run when neither side moves a beat for too long
	initial begin
		stall_count = 0;
		while (stall_count < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty))
				stall_count = 0;
			else
				stall_count++;
		end
		$display("%0t: no beat for %0d cycles, %0d windows outstanding", $time,
				STALL_LIMIT, pending_windows.size());
		$display("Verification failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		push      = 1'b0;
		req       = '0;
		cfg_we    = 1'b0;
		cfg_idx   = CFG_AGG_RATE;
		cfg_wdata = '0;
		agg_rate_m  = RATE_RESET;
		port_rate_m = RATE_RESET;
		latency_m   = '0;
		agg_free_m  = '0;
		for (int i = 0; i < PORTS; i++)
			port_free_m[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_long_hold_off();
		test_sender_pause();
		test_random_traffic();
		test_time_ceiling();

		// drain, then give a stray late beat time to show up
		wait_idle();
		repeat (100) @(posedge clk);

		$display("Sent %0d requests and checked %0d result beats across %0d register writes,",
				items_sent, windows_seen, reg_writes);
		$display("four idle/stall mixes, a long receiver hold-off and the time ceiling.");
		if (mismatches == 0 && pending_windows.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
